// ----- design/npt_pkg.sv -----
// Package for the note-to-pitch tuning map: payload structs, divider request
// and response structs, codes, table depths and the default scale ratios.
// No dependencies.
package npt_pkg;

    localparam int MAP_DEPTH   = 128;
    localparam int SCALE_DEPTH = 128;
    localparam int MAP_AW      = $clog2(MAP_DEPTH);
    localparam int SCALE_AW    = $clog2(SCALE_DEPTH);
    localparam int DIV_W       = 16;

    // Request kinds.
    localparam logic [1:0] KIND_CONVERT  = 2'd0;
    localparam logic [1:0] KIND_MAP_WR   = 2'd1;
    localparam logic [1:0] KIND_SCALE_WR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ZERO_NOTE  = 3'd0;
    localparam logic [2:0] CFG_MAP_SIZE   = 3'd1;
    localparam logic [2:0] CFG_REPEAT_INC = 3'd2;
    localparam logic [2:0] CFG_SCALE_SIZE = 3'd3;
    localparam logic [2:0] CFG_BASE_PITCH = 3'd4;
    localparam logic [2:0] CFG_PERIOD_INV = 3'd5;

    localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0800_0000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [6:0]         note;
        logic [6:0]         table_index;
        logic signed [7:0]  map_degree;
        logic [31:0]        scale_ratio;
    } npt_in_t;

    typedef struct packed {
        logic [31:0] pitch;
        logic        unmapped;
        logic        saturated;
    } npt_out_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [7:0]       divisor;
    } npt_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [7:0]       remainder;
    } npt_div_rsp_t;

    // Twelve-tone equal temperament ratios in Q4.28; entries past twelve read zero.
    function automatic logic [31:0] npt_tet_ratio(input logic [SCALE_AW-1:0] idx);
        logic [31:0] r;
        case (idx)
            7'd0:    r = 32'd284397459;
            7'd1:    r = 32'd301308612;
            7'd2:    r = 32'd319225354;
            7'd3:    r = 32'd338207482;
            7'd4:    r = 32'd358318345;
            7'd5:    r = 32'd379625062;
            7'd6:    r = 32'd402198743;
            7'd7:    r = 32'd426114725;
            7'd8:    r = 32'd451452825;
            7'd9:    r = 32'd478297607;
            7'd10:   r = 32'd506738663;
            7'd11:   r = 32'd536870912;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/npt_div.sv -----
// Serial restoring divider: one quotient bit per cycle, DIV_W quotient bits per request.
// Depends on npt_pkg for the request and response structs.
module npt_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  npt_pkg::npt_div_req_t req,
    output npt_pkg::npt_div_rsp_t rsp
);
    import npt_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic [DIV_W-1:0] quo_reg;
    logic [7:0]       rem_reg;
    logic [7:0]       dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [8:0] trial;
    logic [8:0] diff;
    logic       ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= 8'd0;
            dvs_reg <= req.divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            // The remainder stays below the divisor, so eight bits hold it.
            rem_reg <= ge ? diff[7:0] : trial[7:0];
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- design/note_to_pitch_tuning_map_top.sv -----
// Top level of the note-to-pitch tuning map: sequencer, key map and scale tables,
// configuration registers and the shared multiplier. Depends on npt_pkg and npt_div.
//
// Usage. Requests enter on s_valid/s_ready/s_data. A convert request produces
// one result on m_valid/m_ready/m_data; map and scale writes and unknown kinds
// produce none. Configuration registers are written on cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high and writes are meant for idle
// periods. A write request leaves the sequencer idle. A convert request goes
// through the key map division, the scale division, the octave steps and, for
// a nonzero scale index, the scale step; an unmapped key ends after the key map.
// The serial divider runs twice, once for the key map and once for the scale, and
// each run holds the sequencer until it is done. Each octave step is a decision, a
// multiply and a round cycle on the single 32x32 multiplier; the scale entry adds
// a table read and a load before its own multiply and round. The octave count can
// reach the magnitude of the scale degree when the scale size is small. The block
// holds one request at a time and s_ready is low while a conversion runs.
// Reset restores the register defaults and the default tables at once (valid
// bits per table entry) and the block is ready in the first cycle after reset.
// When the receiver stalls, the result stays in the output register; the block
// still takes the next request and waits at its end until the register frees.
module note_to_pitch_tuning_map_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  npt_pkg::npt_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output npt_pkg::npt_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import npt_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MDIV = 4'd1;
    localparam logic [3:0] ST_MRD  = 4'd2;
    localparam logic [3:0] ST_MCHK = 4'd3;
    localparam logic [3:0] ST_SGO  = 4'd4;
    localparam logic [3:0] ST_SDIV = 4'd5;
    localparam logic [3:0] ST_SRD1 = 4'd6;
    localparam logic [3:0] ST_SLD1 = 4'd7;
    localparam logic [3:0] ST_OCT  = 4'd8;
    localparam logic [3:0] ST_MUL  = 4'd9;
    localparam logic [3:0] ST_RND  = 4'd10;
    localparam logic [3:0] ST_SRD2 = 4'd11;
    localparam logic [3:0] ST_SLD2 = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Configuration registers.
    logic [6:0]  zero_note_reg;
    logic [7:0]  map_size_reg;
    logic [7:0]  rep_inc_reg;
    logic [7:0]  scale_size_reg;
    logic [31:0] base_pitch_reg;
    logic [31:0] pinv_reg;

    // Tables.
    logic [7:0]          key_mem   [MAP_DEPTH];
    logic [31:0]         scale_mem [SCALE_DEPTH];
    logic [MAP_DEPTH-1:0]   key_vld_reg;
    logic [SCALE_DEPTH-1:0] scale_vld_reg;
    logic [7:0]          key_rd_reg;
    logic                key_vld_rd_reg;
    logic [31:0]         scale_rd_reg;
    logic                scale_vld_rd_reg;
    logic [SCALE_AW-1:0] scale_ra_reg;
    logic [SCALE_AW-1:0] scale_addr;
    logic [7:0]          key_entry;
    logic [31:0]         scale_entry;

    // Datapath.
    logic                off_neg_reg;
    logic signed [7:0]   reps_reg;
    logic [MAP_AW-1:0]   idx_reg;
    logic signed [16:0]  degree_reg;
    logic [DIV_W-1:0]    count_reg;
    logic                oct_neg_reg;
    logic [SCALE_AW-1:0] sidx_reg;
    logic [31:0]         acc_reg;
    logic [31:0]         ratio_reg;
    logic [63:0]         prod_reg;
    logic                unm_reg;
    logic                sat_reg;
    logic                last_reg;
    logic                m_valid_reg;
    npt_out_t            m_data_reg;

    logic        s_acc;
    logic        conv_acc;
    logic [7:0]  map_m;
    logic [7:0]  scale_s;
    logic [7:0]  off;
    logic [7:0]  off_abs;
    logic [16:0] deg_abs;
    logic signed [16:0] deg_mul;
    logic signed [16:0] deg_sum;
    logic [63:0] rnd_sum;
    logic [35:0] rnd_val;
    logic        rnd_ovf;
    logic        oct_go;
    logic        out_free;
    logic        rem_nz;

    npt_div_req_t div_req;
    npt_div_rsp_t div_rsp;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign conv_acc  = s_acc && (s_data.kind == KIND_CONVERT);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // A size of zero acts as one, a size past the table depth as the depth.
    always_comb begin
        if (map_size_reg == 8'd0) begin
            map_m = 8'd1;
        end else if (map_size_reg > 8'(MAP_DEPTH)) begin
            map_m = 8'(MAP_DEPTH);
        end else begin
            map_m = map_size_reg;
        end
        if (scale_size_reg == 8'd0) begin
            scale_s = 8'd1;
        end else if (scale_size_reg > 8'(SCALE_DEPTH)) begin
            scale_s = 8'(SCALE_DEPTH);
        end else begin
            scale_s = scale_size_reg;
        end
    end

    assign off     = {1'b0, s_data.note} - {1'b0, zero_note_reg};
    assign off_abs = off[7] ? (8'd0 - off) : off;
    assign deg_abs = degree_reg[16] ? (17'd0 - degree_reg) : degree_reg;
    assign deg_mul = $signed({{9{reps_reg[7]}}, reps_reg}) * $signed({9'd0, rep_inc_reg});
    assign deg_sum = deg_mul + $signed({10'd0, key_entry[6:0]});

    assign div_req.start    = conv_acc || (state_reg == ST_SGO);
    assign div_req.dividend = (state_reg == ST_SGO) ? deg_abs[DIV_W-1:0]
                                                    : {8'd0, off_abs};
    assign div_req.divisor  = (state_reg == ST_SGO) ? scale_s : map_m;

    npt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign rem_nz = (div_rsp.remainder != 8'd0);

    // An entry that was never written reads as its reset value.
    assign key_entry   = key_vld_rd_reg ? key_rd_reg
                                        : ((idx_reg == '0) ? 8'h00 : 8'hFF);
    assign scale_entry = scale_vld_rd_reg ? scale_rd_reg : npt_tet_ratio(scale_ra_reg);
    assign scale_addr  = (state_reg == ST_SRD1) ? SCALE_AW'(scale_s - 8'd1)
                                                : (sidx_reg - SCALE_AW'(1));

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.kind == KIND_MAP_WR) begin
            key_mem[s_data.table_index] <= s_data.map_degree;
        end
        if (s_acc && s_data.kind == KIND_SCALE_WR) begin
            scale_mem[s_data.table_index] <= s_data.scale_ratio;
        end
        key_rd_reg       <= key_mem[idx_reg];
        key_vld_rd_reg   <= key_vld_reg[idx_reg];
        scale_rd_reg     <= scale_mem[scale_addr];
        scale_vld_rd_reg <= scale_vld_reg[scale_addr];
        scale_ra_reg     <= scale_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_vld_reg   <= '0;
            scale_vld_reg <= '0;
        end else begin
            if (s_acc && s_data.kind == KIND_MAP_WR) begin
                key_vld_reg[s_data.table_index] <= 1'b1;
            end
            if (s_acc && s_data.kind == KIND_SCALE_WR) begin
                scale_vld_reg[s_data.table_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_note_reg  <= 7'd0;
            map_size_reg   <= 8'd1;
            rep_inc_reg    <= 8'd1;
            scale_size_reg <= 8'd12;
            base_pitch_reg <= 32'd535810;
            pinv_reg       <= 32'd134217728;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ZERO_NOTE:  zero_note_reg  <= cfg_data[6:0];
                CFG_MAP_SIZE:   map_size_reg   <= cfg_data[7:0];
                CFG_REPEAT_INC: rep_inc_reg    <= cfg_data[7:0];
                CFG_SCALE_SIZE: scale_size_reg <= cfg_data[7:0];
                CFG_BASE_PITCH: base_pitch_reg <= cfg_data;
                CFG_PERIOD_INV: pinv_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rnd_sum = prod_reg + ROUND_HALF;
    assign rnd_val = rnd_sum[63:28];
    assign rnd_ovf = (rnd_val[35:32] != 4'd0);
    assign oct_go  = (count_reg != '0) && (acc_reg != 32'd0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (conv_acc) state_next = ST_MDIV;
            ST_MDIV: if (div_rsp.done) state_next = ST_MRD;
            ST_MRD:  state_next = ST_MCHK;
            ST_MCHK: state_next = key_entry[7] ? ST_DONE : ST_SGO;
            ST_SGO:  state_next = ST_SDIV;
            ST_SDIV: if (div_rsp.done) state_next = ST_SRD1;
            ST_SRD1: state_next = ST_SLD1;
            ST_SLD1: state_next = ST_OCT;
            ST_OCT: begin
                if (oct_go) begin
                    state_next = ST_MUL;
                end else if (sidx_reg != '0) begin
                    state_next = ST_SRD2;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:  state_next = ST_RND;
            ST_RND:  state_next = (rnd_ovf || last_reg) ? ST_DONE : ST_OCT;
            ST_SRD2: state_next = ST_SLD2;
            ST_SLD2: state_next = ST_MUL;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (conv_acc) begin
                    off_neg_reg <= off[7];
                end
            end
            ST_MDIV: begin
                if (div_rsp.done) begin
                    // Floor division: a negative offset with a remainder rounds down.
                    if (!off_neg_reg) begin
                        reps_reg <= $signed({1'b0, div_rsp.quotient[6:0]});
                    end else if (!rem_nz) begin
                        reps_reg <= $signed(8'd0 - {1'b0, div_rsp.quotient[6:0]});
                    end else begin
                        reps_reg <= $signed(~{1'b0, div_rsp.quotient[6:0]});
                    end
                    idx_reg <= (off_neg_reg && rem_nz) ? MAP_AW'(map_m - div_rsp.remainder)
                                                       : div_rsp.remainder[MAP_AW-1:0];
                end
            end
            ST_MCHK: begin
                if (key_entry[7]) begin
                    acc_reg <= 32'd0;
                    unm_reg <= 1'b1;
                    sat_reg <= 1'b0;
                end else begin
                    degree_reg <= deg_sum;
                    unm_reg    <= 1'b0;
                end
            end
            ST_SDIV: begin
                if (div_rsp.done) begin
                    oct_neg_reg <= degree_reg[16];
                    count_reg   <= (degree_reg[16] && rem_nz)
                                   ? (div_rsp.quotient + DIV_W'(1)) : div_rsp.quotient;
                    sidx_reg    <= (degree_reg[16] && rem_nz)
                                   ? SCALE_AW'(scale_s - div_rsp.remainder)
                                   : div_rsp.remainder[SCALE_AW-1:0];
                end
            end
            ST_SLD1: begin
                ratio_reg <= oct_neg_reg ? pinv_reg : scale_entry;
                acc_reg   <= base_pitch_reg;
                sat_reg   <= 1'b0;
                last_reg  <= 1'b0;
            end
            ST_MUL: begin
                prod_reg <= 64'(acc_reg) * 64'(ratio_reg);
            end
            ST_RND: begin
                if (rnd_ovf) begin
                    acc_reg <= 32'hFFFF_FFFF;
                    sat_reg <= 1'b1;
                end else begin
                    acc_reg   <= rnd_val[31:0];
                    count_reg <= count_reg - DIV_W'(1);
                end
            end
            ST_SLD2: begin
                ratio_reg <= scale_entry;
                last_reg  <= 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg.pitch     <= acc_reg;
                    m_data_reg.unmapped  <= unm_reg;
                    m_data_reg.saturated <= sat_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
